[hw/rtl/ilnf_pkg.sv]
// shared constants and codes for the implicit-list next-fit allocator
`default_nettype none
package ilnf_pkg;

  // default store size in bytes
  localparam int unsigned HEAP_BYTES_DEF = 1048576;

  // word and double-word sizes in bytes
  localparam int unsigned WSIZE = 8;
  localparam int unsigned DSIZE = 16;
  localparam int unsigned MIN_BLOCK = 2 * DSIZE;

  // internal address and size arithmetic width
  localparam int unsigned AW = 36;

  // prologue payload and first free block payload
  localparam int unsigned LIST_START = 16;
  localparam int unsigned FIRST_BP = 32;

  // chunk laid down at reset, and reset value of the chunk register
  localparam int unsigned RESET_CHUNK = 256;
  localparam int unsigned RESET_CHUNK_BYTES = RESET_CHUNK * DSIZE;

  // field widths
  localparam int unsigned REQ_W = 21;
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned CHUNK_W = 17;
  localparam int unsigned TAG_W = 32;

  // request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;

  // result codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_NOMEM = 2'd2;

endpackage
`default_nettype wire

[hw/rtl/implicit_list_next_fit_allocator.sv]
// boundary-tag heap allocator with implicit free list and next-fit placement
`default_nettype none
// The block takes one request at a time and finishes it before taking the next. The
// tag store has one read and one write port, so each step of the next-fit walk
// fetches a block header and then checks it, up to HEAP_BYTES/16+4 blocks per pass
// and two passes. Placing the found block writes its header and footer, and when it
// is split also those of the remainder. Growing the heap comes ahead of placement,
// with the tag writes, the merge and the re-read of the header. A free validates the
// header, clears the tags and merges with any free neighbours; a malformed free ends on the
// accepting edge or after one header check. After reset a clearing pass writes the
// initial layout into the store, one word per cycle over all HEAP_BYTES/8 words. No
// request is taken during that pass, but chunk register writes are. Requests use the
// kind in s_axis_tuser (0 allocate, 1 free). Results carry the payload offset in
// m_axis_tdata and the status in m_axis_tuser.
module implicit_list_next_fit_allocator #(
  parameter int unsigned HEAP_BYTES = ilnf_pkg::HEAP_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // chunk register write
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i,
  // request channel
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // req_bytes[20:0], free_addr[40:21], zero fill
  input  wire logic        s_axis_tuser,  // func[0]
  // result channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // block_addr[19:0], zero fill
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  localparam int unsigned AW = ilnf_pkg::AW;
  localparam int unsigned TAG_WORDS = HEAP_BYTES / ilnf_pkg::WSIZE;
  localparam int unsigned IW = $clog2(TAG_WORDS);
  localparam int unsigned WALK_LIMIT = HEAP_BYTES / ilnf_pkg::DSIZE + 4;
  localparam int unsigned NW = $clog2(WALK_LIMIT + 1);
  localparam logic [AW-1:0] HEAP_A = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] LIST_A = AW'(ilnf_pkg::LIST_START);
  localparam logic [AW-1:0] MINB_A = AW'(ilnf_pkg::MIN_BLOCK);
  localparam logic [NW-1:0] WALK_N = NW'(WALK_LIMIT);
  localparam logic [IW-1:0] LAST_IDX = IW'(TAG_WORDS - 1);
  // initial layout word indices
  localparam int unsigned CHUNK_B = ilnf_pkg::RESET_CHUNK_BYTES;
  localparam logic [IW-1:0] IDX_PRO_H = IW'(1);
  localparam logic [IW-1:0] IDX_PRO_F = IW'(2);
  localparam logic [IW-1:0] IDX_FREE_H = IW'(3);
  localparam logic [IW-1:0] IDX_FREE_F = IW'((ilnf_pkg::FIRST_BP + CHUNK_B - 16) / 8);
  localparam logic [IW-1:0] IDX_EPI = IW'((ilnf_pkg::FIRST_BP + CHUNK_B - 8) / 8);
  localparam logic [AW-1:0] BRK_RST = AW'(ilnf_pkg::FIRST_BP + CHUNK_B);

  typedef enum logic [24:0] {
    ST_INIT = 25'd1 << 0,
    ST_IDLE = 25'd1 << 1,
    ST_SRCH = 25'd1 << 2,
    ST_SCHK = 25'd1 << 3,
    ST_GROW = 25'd1 << 4,
    ST_GW0  = 25'd1 << 5,
    ST_GW1  = 25'd1 << 6,
    ST_GW2  = 25'd1 << 7,
    ST_M0   = 25'd1 << 8,
    ST_M1   = 25'd1 << 9,
    ST_M2   = 25'd1 << 10,
    ST_M3   = 25'd1 << 11,
    ST_M4   = 25'd1 << 12,
    ST_MW0  = 25'd1 << 13,
    ST_MW1  = 25'd1 << 14,
    ST_GRD  = 25'd1 << 15,
    ST_GCHK = 25'd1 << 16,
    ST_SET  = 25'd1 << 17,
    ST_SW0  = 25'd1 << 18,
    ST_SW1  = 25'd1 << 19,
    ST_SW2  = 25'd1 << 20,
    ST_SW3  = 25'd1 << 21,
    ST_FCHK = 25'd1 << 22,
    ST_FW0  = 25'd1 << 23,
    ST_FW1  = 25'd1 << 24
  } state_e;

  state_e state_q, state_d;

  logic [ilnf_pkg::TAG_W-1:0] mem [TAG_WORDS];
  logic [ilnf_pkg::TAG_W-1:0] rdata_q;
  logic                       rd_oob_q;

  logic [AW-1:0] bp_q, bp_d, sz_q, sz_d, nsz_q, nsz_d, prv_q, prv_d;
  logic [AW-1:0] need_q, need_d, have_q, have_d, rest_q, rest_d;
  logic [AW-1:0] brk_q, brk_d, rover_q, rover_d;
  logic [AW-1:0] a0_q, a0_d, a1_q, a1_d, mv_q, mv_d, mbp_q, mbp_d;
  logic          pa_q, pa_d, na_q, na_d, phase_q, phase_d, free_q, free_d;
  logic          split_q, split_d;
  logic [NW-1:0] n_q, n_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [ilnf_pkg::CHUNK_W-1:0] chunk_q;

  logic                       rd_en, mem_we;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic [ilnf_pkg::TAG_W-1:0] wr_val;
  logic                       res_en;
  logic [AW-1:0]              res_addr;
  logic [1:0]                 res_status;

  logic [ilnf_pkg::TAG_W-1:0] tag;
  logic [AW-1:0]              tsize;
  logic [ilnf_pkg::REQ_W-1:0] in_req;
  logic [AW-1:0]              in_fa;
  logic [AW-1:0]              chunk_b, gsize;
  logic [ilnf_pkg::TAG_W-1:0] init_val;
  logic                       s_acc;

  assign in_req = s_axis_tdata[20:0];
  assign in_fa = AW'(s_axis_tdata[40:21]);
  assign tag = rd_oob_q ? '0 : rdata_q;
  assign tsize = AW'({tag[31:3], 3'b000});
  assign chunk_b = AW'({chunk_q, 4'b0000});
  assign gsize = (need_q > chunk_b) ? need_q : chunk_b;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // initial layout word for the clearing pass
  always_comb begin
    init_val = '0;
    if (clr_q == IDX_PRO_H || clr_q == IDX_PRO_F) init_val = 32'(ilnf_pkg::DSIZE + 1);
    if (clr_q == IDX_FREE_H || clr_q == IDX_FREE_F) init_val = 32'(CHUNK_B);
    if (clr_q == IDX_EPI) init_val = 32'd1;
  end

  // tag store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we && wr_addr < HEAP_A) mem[wr_addr[IW+2:3]] <= wr_val;
    if (rd_en) rdata_q <= mem[rd_addr[IW+2:3]];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    bp_d = bp_q; sz_d = sz_q; nsz_d = nsz_q; prv_d = prv_q;
    need_d = need_q; have_d = have_q; rest_d = rest_q;
    brk_d = brk_q; rover_d = rover_q;
    a0_d = a0_q; a1_d = a1_q; mv_d = mv_q; mbp_d = mbp_q;
    pa_d = pa_q; na_d = na_q; phase_d = phase_q; free_d = free_q; split_d = split_q;
    n_d = n_q; clr_d = clr_q;
    rd_en = 1'b0; rd_addr = '0;
    mem_we = 1'b0; wr_addr = '0; wr_val = '0;
    res_en = 1'b0; res_addr = '0; res_status = ilnf_pkg::STATUS_OK;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        wr_addr = AW'({clr_q, 3'b000});
        wr_val = init_val;
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = !m_axis_tvalid || m_axis_tready;
        if (s_axis_tvalid && (!m_axis_tvalid || m_axis_tready)) begin
          if (s_axis_tuser == ilnf_pkg::FUNC_FREE) begin
            free_d = 1'b1;
            bp_d = in_fa;
            if (in_fa[3:0] == 4'd0 && in_fa >= AW'(ilnf_pkg::FIRST_BP) && in_fa < brk_q) begin
              rd_en = 1'b1;
              rd_addr = in_fa - AW'(8);
              state_d = ST_FCHK;
            end else begin
              res_en = 1'b1;
            end
          end else if (in_req == '0) begin
            res_en = 1'b1;
            res_status = ilnf_pkg::STATUS_ZERO;
          end else begin
            free_d = 1'b0;
            need_d = (in_req <= 21'd16) ? MINB_A
                   : AW'({(22'(in_req) + 22'd31) >> 4, 4'b0000});
            bp_d = rover_q;
            n_d = '0;
            phase_d = 1'b0;
            state_d = ST_SRCH;
          end
        end
      end
      // walk step: check bounds then fetch header
      ST_SRCH: begin
        if (n_q < WALK_N && bp_q < brk_q && (!phase_q || bp_q != rover_q)) begin
          rd_en = 1'b1;
          rd_addr = bp_q - AW'(8);
          state_d = ST_SCHK;
        end else if (!phase_q) begin
          bp_d = LIST_A; n_d = '0; phase_d = 1'b1;
        end else begin
          state_d = ST_GROW;
        end
      end
      ST_SCHK: begin
        if (tsize == '0) begin
          if (!phase_q) begin
            bp_d = LIST_A; n_d = '0; phase_d = 1'b1;
            state_d = ST_SRCH;
          end else begin
            state_d = ST_GROW;
          end
        end else if (!tag[0] && need_q <= tsize) begin
          have_d = tsize;
          state_d = ST_SET;
        end else begin
          bp_d = bp_q + tsize;
          n_d = n_q + 1'b1;
          state_d = ST_SRCH;
        end
      end
      // heap growth
      ST_GROW: begin
        if (brk_q > HEAP_A || gsize > HEAP_A - brk_q) begin
          res_en = 1'b1;
          res_status = ilnf_pkg::STATUS_NOMEM;
          state_d = ST_IDLE;
        end else begin
          bp_d = brk_q;
          sz_d = gsize;
          brk_d = brk_q + gsize;
          state_d = ST_GW0;
        end
      end
      ST_GW0: begin
        mem_we = 1'b1; wr_addr = bp_q - AW'(8); wr_val = sz_q[31:0];
        state_d = ST_GW1;
      end
      ST_GW1: begin
        mem_we = 1'b1; wr_addr = bp_q + sz_q - AW'(16); wr_val = sz_q[31:0];
        state_d = ST_GW2;
      end
      ST_GW2: begin
        mem_we = 1'b1; wr_addr = bp_q + sz_q - AW'(8); wr_val = 32'd1;
        state_d = ST_M0;
      end
      // coalescing
      ST_M0: begin
        rd_en = 1'b1; rd_addr = bp_q - AW'(8);
        state_d = ST_M1;
      end
      ST_M1: begin
        sz_d = tsize;
        rd_en = 1'b1; rd_addr = bp_q - AW'(16);
        state_d = ST_M2;
      end
      ST_M2: begin
        pa_d = tag[0];
        prv_d = bp_q - tsize;
        rd_en = 1'b1; rd_addr = bp_q + sz_q - AW'(8);
        state_d = ST_M3;
      end
      ST_M3: begin
        na_d = tag[0];
        nsz_d = tsize;
        if (pa_q && tag[0]) begin
          if (free_q) begin
            res_en = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_GRD;
          end
        end else if (pa_q) begin
          mv_d = sz_q + tsize;
          a0_d = bp_q - AW'(8);
          a1_d = bp_q + sz_q + tsize - AW'(16);
          mbp_d = bp_q;
          state_d = ST_MW0;
        end else begin
          rd_en = 1'b1; rd_addr = prv_q - AW'(8);
          state_d = ST_M4;
        end
      end
      ST_M4: begin
        mbp_d = prv_q;
        if (na_q) begin
          mv_d = sz_q + tsize;
          a0_d = bp_q + sz_q - AW'(16);
          a1_d = prv_q - AW'(8);
        end else begin
          mv_d = sz_q + tsize + nsz_q;
          a0_d = prv_q - AW'(8);
          a1_d = bp_q + sz_q + nsz_q - AW'(16);
        end
        state_d = ST_MW0;
      end
      ST_MW0: begin
        mem_we = 1'b1; wr_addr = a0_q; wr_val = mv_q[31:0];
        state_d = ST_MW1;
      end
      ST_MW1: begin
        mem_we = 1'b1; wr_addr = a1_q; wr_val = mv_q[31:0];
        bp_d = mbp_q;
        rover_d = mbp_q;
        if (free_q) begin
          res_en = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_GRD;
        end
      end
      // re-read header of grown block
      ST_GRD: begin
        rd_en = 1'b1; rd_addr = bp_q - AW'(8);
        state_d = ST_GCHK;
      end
      ST_GCHK: begin
        have_d = tsize;
        state_d = ST_SET;
      end
      // placement and split
      ST_SET: begin
        rest_d = (have_q >= need_q) ? have_q - need_q : '0;
        split_d = ((have_q >= need_q) ? have_q - need_q : '0) >= MINB_A;
        state_d = ST_SW0;
      end
      ST_SW0: begin
        mem_we = 1'b1; wr_addr = bp_q - AW'(8);
        wr_val = split_q ? (need_q[31:0] | 32'd1) : (have_q[31:0] | 32'd1);
        state_d = ST_SW1;
      end
      ST_SW1: begin
        mem_we = 1'b1;
        wr_addr = split_q ? bp_q + need_q - AW'(16) : bp_q + have_q - AW'(16);
        wr_val = split_q ? (need_q[31:0] | 32'd1) : (have_q[31:0] | 32'd1);
        if (split_q) begin
          state_d = ST_SW2;
        end else begin
          res_en = 1'b1; res_addr = bp_q;
          state_d = ST_IDLE;
        end
      end
      ST_SW2: begin
        mem_we = 1'b1; wr_addr = bp_q + need_q - AW'(8); wr_val = rest_q[31:0];
        state_d = ST_SW3;
      end
      ST_SW3: begin
        mem_we = 1'b1; wr_addr = bp_q + need_q + rest_q - AW'(16); wr_val = rest_q[31:0];
        res_en = 1'b1; res_addr = bp_q;
        state_d = ST_IDLE;
      end
      // free validation and tag clearing
      ST_FCHK: begin
        if (tag[0] && tsize >= MINB_A && tsize <= brk_q - bp_q + AW'(8)) begin
          sz_d = tsize;
          state_d = ST_FW0;
        end else begin
          res_en = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FW0: begin
        mem_we = 1'b1; wr_addr = bp_q - AW'(8); wr_val = sz_q[31:0];
        state_d = ST_FW1;
      end
      ST_FW1: begin
        mem_we = 1'b1; wr_addr = bp_q + sz_q - AW'(16); wr_val = sz_q[31:0];
        state_d = ST_M0;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      clr_q <= '0;
      brk_q <= BRK_RST;
      rover_q <= AW'(ilnf_pkg::FIRST_BP);
      chunk_q <= ilnf_pkg::CHUNK_W'(ilnf_pkg::RESET_CHUNK);
      rd_oob_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
      n_q <= '0;
      phase_q <= 1'b0;
      free_q <= 1'b0;
      pa_q <= 1'b0;
      na_q <= 1'b0;
      split_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      brk_q <= brk_d;
      rover_q <= rover_d;
      if (cfg_we_i) chunk_q <= cfg_wdata_i;
      if (rd_en) rd_oob_q <= rd_addr >= HEAP_A;
      if (res_en) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      n_q <= n_d;
      phase_q <= phase_d;
      free_q <= free_d;
      pa_q <= pa_d;
      na_q <= na_d;
      split_q <= split_d;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    bp_q <= bp_d; sz_q <= sz_d; nsz_q <= nsz_d; prv_q <= prv_d;
    need_q <= need_d; have_q <= have_d; rest_q <= rest_d;
    a0_q <= a0_d; a1_q <= a1_d; mv_q <= mv_d; mbp_q <= mbp_d;
    if (res_en) begin
      m_axis_tdata <= {4'b0000, res_addr[ilnf_pkg::ADDR_W-1:0]};
      m_axis_tuser <= res_status;
    end
  end

`ifndef SYNTH
  // break stays inside the store and double-word aligned
  a_brk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= HEAP_A && brk_q[3:0] == 4'd0)
    else $error("break out of range");

  // a request is taken only when the result slot is free
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> (!m_axis_tvalid || m_axis_tready))
    else $error("request taken over pending result");

  // no request during the clearing pass
  a_init_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INIT |-> !s_axis_tready)
    else $error("ready during clearing pass");

  // a result is raised only out of a working state or idle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_en |-> state_d == ST_IDLE || state_d == ST_GRD || state_q == ST_IDLE)
    else $error("result raised mid-operation");
`endif

endmodule
`default_nettype wire
